// ----- rtl/steu_pkg.sv -----
// steu_pkg: shared types, opcodes, register indexes and trap tables of the trap entry unit
// no dependencies
`default_nettype none

package steu_pkg;

    localparam int TABLE_ENTRIES = 22;
    localparam int TBR_BASE_W    = 20;
    localparam int WCOUNT_W      = 6;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = TBR_BASE_W;

    localparam logic [WCOUNT_W-1:0] WCOUNT_MIN   = 6'd2;
    localparam logic [WCOUNT_W-1:0] WCOUNT_MAX   = 6'd32;
    localparam logic [WCOUNT_W-1:0] WCOUNT_RESET = 6'd8;

    typedef enum logic [1:0] {
        OP_POST_EXC = 2'd0,
        OP_POST_IRQ = 2'd1,
        OP_ENTER    = 2'd2,
        OP_RSVD     = 2'd3
    } steu_op_t;

    localparam logic [CFG_INDEX_W-1:0] REG_TBR_BASE     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_COUNT = 2'd1;

    localparam logic [7:0] TT_WIN_OVERFLOW  = 8'h05;
    localparam logic [7:0] TT_WIN_UNDERFLOW = 8'h06;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  code;
        logic        cur_et;
        logic        cur_s;
        logic [3:0]  cur_pil;
        logic [4:0]  cur_cwp;
        logic [31:0] cur_pc;
        logic [31:0] cur_npc;
    } steu_evt_t;

    typedef struct packed {
        logic        status;
        logic        entered;
        logic        new_et;
        logic        new_s;
        logic        new_ps;
        logic [4:0]  new_cwp;
        logic [31:0] new_pc;
        logic [31:0] new_npc;
        logic [7:0]  tbr_tt;
        logic [7:0]  posted_tt;
        logic        irq_waiting;
        logic [4:0]  irq_tt;
    } steu_res_t;

    typedef struct packed {
        logic [7:0] posted_trap;
        logic [4:0] pending_irq_tt;
        logic       pending_irq_valid;
        logic [7:0] tt_field;
    } steu_state_t;

    // exception index to tt
    function automatic logic [7:0] exc_tt_map(input logic [4:0] idx);
        logic [7:0] tt;
        begin
            unique case (idx)
                5'd0:    tt = 8'h00;
                5'd1:    tt = 8'h2B;
                5'd2:    tt = 8'h3C;
                5'd3:    tt = 8'h21;
                5'd4:    tt = 8'h20;
                5'd5:    tt = 8'h01;
                5'd6:    tt = 8'h03;
                5'd7:    tt = 8'h02;
                5'd8:    tt = 8'h04;
                5'd9:    tt = 8'h24;
                5'd10:   tt = 8'h25;
                5'd11:   tt = 8'h0B;
                5'd12:   tt = 8'h05;
                5'd13:   tt = 8'h06;
                5'd14:   tt = 8'h07;
                5'd15:   tt = 8'h08;
                5'd16:   tt = 8'h28;
                5'd17:   tt = 8'h29;
                5'd18:   tt = 8'h2C;
                5'd19:   tt = 8'h09;
                5'd20:   tt = 8'h0A;
                5'd21:   tt = 8'h2A;
                default: tt = 8'h00;
            endcase
            return tt;
        end
    endfunction

    // tt is a hardware exception or a software trap
    function automatic logic is_exception_tt(input logic [7:0] tt);
        logic hit;
        begin
            case (tt) inside
                8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
                8'h08, 8'h09, 8'h0A, 8'h0B, 8'h20, 8'h21, 8'h24, 8'h25,
                8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3C: hit = 1'b1;
                default:                                  hit = tt[7];
            endcase
            return hit;
        end
    endfunction

    function automatic logic [WCOUNT_W-1:0] sat_window_count(input logic [WCOUNT_W-1:0] wc);
        logic [WCOUNT_W-1:0] r;
        begin
            if (wc < WCOUNT_MIN)
                r = WCOUNT_MIN;
            else if (wc > WCOUNT_MAX)
                r = WCOUNT_MAX;
            else
                r = wc;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/steu_wdec.sv -----
// steu_wdec: window pointer decrement modulo the window count
// depends on steu_pkg
`default_nettype none

module steu_wdec
    import steu_pkg::*;
(
    input  wire logic [4:0]          cwp,
    input  wire logic [WCOUNT_W-1:0] window_count,
    output logic      [4:0]          new_cwp
);

    logic [WCOUNT_W-1:0] wc_sat;
    logic [WCOUNT_W:0]   rem;
    logic [WCOUNT_W-1:0] wc_dec;

    assign wc_sat = sat_window_count(window_count);
    assign wc_dec = wc_sat - 6'd1;

    // five-step restoring remainder, remainder stays below wc_sat
    always_comb
    begin
        rem = '0;
        for (int i = 4; i >= 0; i--)
        begin
            rem = {rem[WCOUNT_W-1:0], cwp[i]};
            if (rem >= {1'b0, wc_sat})
                rem = rem - {1'b0, wc_sat};
        end
        if (rem == '0)
            new_cwp = wc_dec[4:0];
        else
            new_cwp = rem[4:0] - 5'd1;
    end

endmodule

`default_nettype wire

// ----- rtl/steu_step.sv -----
// steu_step: decision logic for one trap event, result and next trap state
// depends on steu_pkg and steu_wdec
`default_nettype none

module steu_step
    import steu_pkg::*;
(
    input  wire steu_evt_t                  evt,
    input  wire steu_state_t                state,
    input  wire logic [TBR_BASE_W-1:0]      tbr_base,
    input  wire logic [WCOUNT_W-1:0]        window_count,
    output steu_res_t                       res,
    output steu_state_t                     state_next
);

    logic [4:0]  dec_cwp;
    logic        do_entry;
    logic        irq_ok;
    logic [31:0] vec;

    steu_wdec u_wdec (
        .cwp          (evt.cur_cwp),
        .window_count (window_count),
        .new_cwp      (dec_cwp)
    );

    assign do_entry = evt.cur_et || (evt.code == TT_WIN_OVERFLOW)
                    || (evt.code == TT_WIN_UNDERFLOW);
    assign irq_ok   = evt.cur_et && ((evt.code[3:0] >= evt.cur_pil) || (evt.code[3:0] == 4'hF));
    assign vec      = {tbr_base, evt.code, 4'b0000};

    always_comb
    begin
        state_next  = state;
        res.status  = 1'b0;
        res.entered = 1'b0;
        res.new_et  = evt.cur_et;
        res.new_s   = evt.cur_s;
        res.new_ps  = 1'b0;
        res.new_cwp = evt.cur_cwp;
        res.new_pc  = evt.cur_pc;
        res.new_npc = evt.cur_npc;

        unique case (steu_op_t'(evt.op))
            OP_POST_EXC:
            begin
                if (state.pending_irq_valid)
                    res.status = 1'b1;
                else if (evt.code >= 8'(TABLE_ENTRIES))
                    state_next.posted_trap = evt.code;
                else
                    state_next.posted_trap = exc_tt_map(evt.code[4:0]);
            end
            OP_POST_IRQ:
            begin
                // level zero or above fifteen never posts
                if ((evt.code[7:4] != 4'h0) || (evt.code[3:0] == 4'h0) || !irq_ok)
                    res.status = 1'b1;
                else
                begin
                    state_next.pending_irq_tt    = {1'b1, evt.code[3:0]};
                    state_next.pending_irq_valid = 1'b1;
                end
            end
            OP_ENTER:
            begin
                if (do_entry)
                begin
                    state_next.tt_field = evt.code;
                    res.new_ps  = evt.cur_s;
                    res.new_s   = 1'b1;
                    res.new_et  = 1'b0;
                    res.new_cwp = dec_cwp;
                    res.new_pc  = vec;
                    res.new_npc = {vec[31:4], 4'b0100};
                    res.entered = 1'b1;
                end
                // non-exception tt is taken as the interrupt being served
                if (!is_exception_tt(evt.code))
                    state_next.pending_irq_valid = 1'b0;
            end
            default:
            begin
                res.status = 1'b1;
            end
        endcase

        res.tbr_tt      = state_next.tt_field;
        res.posted_tt   = state_next.posted_trap;
        res.irq_waiting = state_next.pending_irq_valid;
        res.irq_tt      = state_next.pending_irq_tt;
    end

endmodule

`default_nettype wire

// ----- rtl/sparc_trap_entry_unit_core.sv -----
// sparc_trap_entry_unit_core: top level of the trap entry unit, event and result registers
// depends on steu_pkg, steu_step, steu_wdec
//
// usage
//   events (evt) enter on evt_valid with evt_stall low; each event gives
//   exactly one result word (res) on res_valid, taken when res_stall is low.
//   an event is registered at acceptance, evaluated against the trap state
//   while it sits in the event register and loaded into the result register
//   at an edge on which the result register is free. one word per cycle is
//   sustained while res_stall is low; the only loop is the trap state
//   register updated by the combinational step logic.
//   when res_stall is held the result register holds, then the event
//   register fills and evt_stall rises; no word is dropped.
//   cfg writes (cfg_valid, cfg_ready always high) set tbr_base at index 0
//   and window_count at index 1; other indexes are ignored. write only
//   while no event is in flight.
//   reset clears all trap state, tbr_base to zero and window_count to 8.
`default_nettype none

module sparc_trap_entry_unit_core
    import steu_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   evt_valid,
    output logic                        evt_stall,
    input  wire steu_evt_t              evt,
    output logic                        res_valid,
    input  wire logic                   res_stall,
    output steu_res_t                   res,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                  evt_valid_reg;
    steu_evt_t             evt_reg;
    logic                  res_valid_reg;
    steu_res_t             res_reg;
    steu_state_t           state_reg;
    steu_state_t           state_next;
    steu_res_t             res_next;
    logic [TBR_BASE_W-1:0] tbr_base_reg;
    logic [WCOUNT_W-1:0]   wcount_reg;
    logic                  res_free;
    logic                  evt_adv;

    assign res_free  = !res_valid_reg || !res_stall;
    assign evt_adv   = evt_valid_reg && res_free;
    assign evt_stall = evt_valid_reg && !res_free;
    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    steu_step u_step (
        .evt          (evt_reg),
        .state        (state_reg),
        .tbr_base     (tbr_base_reg),
        .window_count (wcount_reg),
        .res          (res_next),
        .state_next   (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
            tbr_base_reg  <= '0;
            wcount_reg    <= WCOUNT_RESET;
        end
        else
        begin
            if (!evt_stall)
                evt_valid_reg <= evt_valid;
            if (res_free)
                res_valid_reg <= evt_valid_reg;
            if (evt_adv)
                state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_TBR_BASE:     tbr_base_reg <= cfg_data[TBR_BASE_W-1:0];
                    REG_WINDOW_COUNT: wcount_reg   <= cfg_data[WCOUNT_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_valid && !evt_stall)
            evt_reg <= evt;
        if (evt_adv)
            res_reg <= res_next;
    end

    // entry always leaves supervisor mode set and traps disabled
    a_entry_psr: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.entered) |-> (res.new_s && !res.new_et))
        else $error("trap entry result with bad psr bits");

    // a pending interrupt always carries tt of a nonzero level plus 0x10
    a_irq_tt: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.irq_waiting) |-> (res.irq_tt[4] && (res.irq_tt[3:0] != 4'h0)))
        else $error("pending interrupt tt out of range");

    // new window pointer stays inside the configured window count
    a_cwp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.entered)
            |-> ({1'b0, res.new_cwp} < sat_window_count(wcount_reg)))
        else $error("window pointer beyond window count");

    // a blocked event stays in the event register
    a_evt_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid_reg && !res_free) |=> evt_valid_reg)
        else $error("stalled event lost");

endmodule

`default_nettype wire
